[rtl/ttsc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttsc_pkg
// Shared types and constants for the touch tap/swipe classifier.
// ----------------------------------------------------------------------------
package ttsc_pkg;

    localparam int COORD_W   = 12;
    localparam int MS_W      = 16;
    localparam int NORM_W    = 10;

    // Fixed-point reciprocal used for permille scaling
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = 30;
    localparam int PROD_W      = COORD_W + RECIP_W;

    localparam logic [NORM_W-1:0] NORM_MAX = 10'd1000;

    localparam logic [COORD_W-1:0] THRESHOLD_RESET = 12'd61;
    localparam logic [MS_W-1:0]    MAX_MS_RESET    = 16'd800;

    localparam logic KIND_TAP   = 1'b0;
    localparam logic KIND_SWIPE = 1'b1;

    localparam logic [1:0] DIR_RIGHT = 2'd0;
    localparam logic [1:0] DIR_LEFT  = 2'd1;
    localparam logic [1:0] DIR_DOWN  = 2'd2;
    localparam logic [1:0] DIR_UP    = 2'd3;

    typedef struct packed {
        logic              kind;
        logic [NORM_W-1:0] norm_x;
        logic [NORM_W-1:0] norm_y;
        logic [1:0]        dir;
    } result_t;

    typedef struct packed {
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] last_x;
        logic [COORD_W-1:0] last_y;
        logic [NORM_W-1:0]  norm_x;
        logic [NORM_W-1:0]  norm_y;
    } track_t;

endpackage

[rtl/ttsc_classify.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttsc_classify
// Turns the tracked start and last points into a tap or swipe result.
// ----------------------------------------------------------------------------
module ttsc_classify
(
    input  ttsc_pkg::track_t                 track,
    input  logic [ttsc_pkg::COORD_W-1:0]     threshold,
    output ttsc_pkg::result_t                result
);

    logic [ttsc_pkg::COORD_W-1:0] adx;
    logic [ttsc_pkg::COORD_W-1:0] ady;
    logic                         is_tap;

    always_comb
    begin
        adx = (track.last_x >= track.start_x) ? (track.last_x - track.start_x)
                                              : (track.start_x - track.last_x);
        ady = (track.last_y >= track.start_y) ? (track.last_y - track.start_y)
                                              : (track.start_y - track.last_y);
        is_tap = (adx < threshold) && (ady < threshold);

        result = '0;
        if (is_tap)
        begin
            result.kind   = ttsc_pkg::KIND_TAP;
            result.norm_x = track.norm_x;
            result.norm_y = track.norm_y;
            result.dir    = ttsc_pkg::DIR_RIGHT;
        end
        else
        begin
            result.kind = ttsc_pkg::KIND_SWIPE;
            // vertical axis wins a tie
            if (adx > ady)
                result.dir = (track.last_x > track.start_x) ? ttsc_pkg::DIR_RIGHT
                                                            : ttsc_pkg::DIR_LEFT;
            else
                result.dir = (track.last_y > track.start_y) ? ttsc_pkg::DIR_DOWN
                                                            : ttsc_pkg::DIR_UP;
        end
    end

endmodule

[rtl/touch_tap_swipe_classifier_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_tap_swipe_classifier_unit
// Classifies touch poll samples into tap and swipe gestures.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake                  Payload
//  sample    in   sample_valid/sample_stall  read_ok, finger_present,
//                                            touch_x, touch_y, now_ms
//  gesture   out  gesture_valid/gesture_stall gesture_kind, norm_x, norm_y,
//                                            swipe_dir
//  config    in   APB (psel/penable/pready)  swipe_threshold @0x0,
//                                            max_gesture_ms  @0x4
//
//  One sample beat per cycle sustained while no result waits on a stalled
//  output. A beat is captured in the sample register; as it advances, the
//  gesture state is updated and any result beat is written to the output
//  register. Reset (rst_n low, asynchronous) clears both stages and arms
//  the tracker. A stalled result holds the output register; the sample
//  register keeps taking a beat until it would have to overwrite that
//  result, and then sample_stall rises.
//
module touch_tap_swipe_classifier_unit
#(
    parameter int PANEL_WIDTH  = 410,
    parameter int PANEL_HEIGHT = 502
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        sample_valid,
    output logic        sample_stall,
    input  logic        read_ok,
    input  logic        finger_present,
    input  logic [11:0] touch_x,
    input  logic [11:0] touch_y,
    input  logic [15:0] now_ms,

    output logic        gesture_valid,
    input  logic        gesture_stall,
    output logic        gesture_kind,
    output logic [9:0]  norm_x,
    output logic [9:0]  norm_y,
    output logic [1:0]  swipe_dir,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Phase codes of the gesture tracker
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_ACTIVE = 2'd1;
    localparam logic [1:0] PH_WAIT   = 2'd2;

    localparam int CW = ttsc_pkg::COORD_W;
    localparam int MW = ttsc_pkg::MS_W;
    localparam int NW = ttsc_pkg::NORM_W;
    localparam int RS = ttsc_pkg::RECIP_SHIFT;
    localparam int RW = ttsc_pkg::RECIP_W;
    localparam int PW = ttsc_pkg::PROD_W;

    // ceil(1000 * 2^RS / span): exact floor(v*1000/span) for 12-bit v and span
    localparam logic [63:0] RECIP_X_FULL =
        ((64'd1000 << RS) + 64'(PANEL_WIDTH) - 64'd1) / 64'(PANEL_WIDTH);
    localparam logic [63:0] RECIP_Y_FULL =
        ((64'd1000 << RS) + 64'(PANEL_HEIGHT) - 64'd1) / 64'(PANEL_HEIGHT);
    localparam logic [RW-1:0] RECIP_X = RECIP_X_FULL[RW-1:0];
    localparam logic [RW-1:0] RECIP_Y = RECIP_Y_FULL[RW-1:0];
    localparam logic [CW-1:0] SPAN_X  = CW'(PANEL_WIDTH);
    localparam logic [CW-1:0] SPAN_Y  = CW'(PANEL_HEIGHT);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CW-1:0] threshold_reg;
    logic [MW-1:0] max_ms_reg;
    logic          cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= ttsc_pkg::THRESHOLD_RESET;
            max_ms_reg    <= ttsc_pkg::MAX_MS_RESET;
        end
        else if (cfg_write)
        begin
            // decode on the word address; byte offset bits are ignored
            if (paddr[2])
                max_ms_reg <= pwdata[MW-1:0];
            else
                threshold_reg <= pwdata[CW-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2])
            prdata = {{(32-MW){1'b0}}, max_ms_reg};
        else
            prdata = {{(32-CW){1'b0}}, threshold_reg};
    end

    // ------------------------------------------------------------------
    // Sample register
    // ------------------------------------------------------------------
    logic          s1_valid_reg;
    logic          s1_valid_next;
    logic          s1_ok_reg;
    logic          s1_finger_reg;
    logic [CW-1:0] s1_x_reg;
    logic [CW-1:0] s1_y_reg;
    logic [MW-1:0] s1_ms_reg;

    logic          sample_accept;
    logic          s1_adv;
    logic          produce;
    logic          out_free;

    assign out_free      = !gesture_valid || !gesture_stall;
    assign s1_adv        = s1_valid_reg && (!produce || out_free);
    assign sample_stall  = s1_valid_reg && !s1_adv;
    assign sample_accept = sample_valid && !sample_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (sample_accept)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    // Payload only; no reset needed
    always_ff @(posedge clk)
    begin
        if (sample_accept)
        begin
            s1_ok_reg     <= read_ok;
            s1_finger_reg <= finger_present;
            s1_x_reg      <= touch_x;
            s1_y_reg      <= touch_y;
            s1_ms_reg     <= now_ms;
        end
    end

    // ------------------------------------------------------------------
    // Gesture tracker
    // ------------------------------------------------------------------
    logic [1:0]        phase_reg;
    logic [1:0]        phase_next;
    ttsc_pkg::track_t  track_reg;
    ttsc_pkg::track_t  track_next;
    logic [MW-1:0]     start_ms_reg;
    logic [MW-1:0]     start_ms_next;
    logic [MW-1:0]     elapsed;
    logic              good_touch;
    logic              good_lift;
    logic [PW-1:0]     prod_x;
    logic [PW-1:0]     prod_y;
    logic [NW-1:0]     scaled_x;
    logic [NW-1:0]     scaled_y;

    assign good_touch = s1_ok_reg && s1_finger_reg;
    assign good_lift  = s1_ok_reg && !s1_finger_reg;
    assign elapsed    = s1_ms_reg - start_ms_reg;

    // Permille scaling of the start point, taken once when a gesture opens
    assign prod_x   = PW'(s1_x_reg) * PW'(RECIP_X);
    assign prod_y   = PW'(s1_y_reg) * PW'(RECIP_Y);
    assign scaled_x = (s1_x_reg >= SPAN_X) ? ttsc_pkg::NORM_MAX : prod_x[RS+NW-1:RS];
    assign scaled_y = (s1_y_reg >= SPAN_Y) ? ttsc_pkg::NORM_MAX : prod_y[RS+NW-1:RS];

    always_comb
    begin
        phase_next    = phase_reg;
        track_next    = track_reg;
        start_ms_next = start_ms_reg;
        produce       = 1'b0;
        case (phase_reg)
            PH_IDLE:
            begin
                // open a gesture on a good touch; drop anything else
                if (good_touch)
                begin
                    track_next.start_x = s1_x_reg;
                    track_next.start_y = s1_y_reg;
                    track_next.last_x  = s1_x_reg;
                    track_next.last_y  = s1_y_reg;
                    track_next.norm_x  = scaled_x;
                    track_next.norm_y  = scaled_y;
                    start_ms_next      = s1_ms_reg;
                    phase_next         = PH_ACTIVE;
                end
            end
            PH_ACTIVE:
            begin
                if (!good_touch)
                begin
                    // lift re-arms at once; a failed read waits for a lift
                    produce    = 1'b1;
                    phase_next = good_lift ? PH_IDLE : PH_WAIT;
                end
                else if (elapsed > max_ms_reg)
                begin
                    // time cap: resolve without taking this position
                    produce    = 1'b1;
                    phase_next = PH_WAIT;
                end
                else
                begin
                    track_next.last_x = s1_x_reg;
                    track_next.last_y = s1_y_reg;
                end
            end
            PH_WAIT:
            begin
                if (good_lift)
                    phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            track_reg    <= '0;
            start_ms_reg <= '0;
        end
        else if (s1_adv)
        begin
            phase_reg    <= phase_next;
            track_reg    <= track_next;
            start_ms_reg <= start_ms_next;
        end
    end

    // ------------------------------------------------------------------
    // Classification and result register
    // ------------------------------------------------------------------
    ttsc_pkg::result_t result;
    ttsc_pkg::result_t out_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              push;

    ttsc_classify u_classify
    (
        .track     (track_reg),
        .threshold (threshold_reg),
        .result    (result)
    );

    assign push = s1_adv && produce;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (push)
            out_valid_next = 1'b1;
        else if (!gesture_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            out_reg <= result;
    end

    assign gesture_valid = out_valid_reg;
    assign gesture_kind  = out_reg.kind;
    assign norm_x        = out_reg.norm_x;
    assign norm_y        = out_reg.norm_y;
    assign swipe_dir     = out_reg.dir;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_push_only_active: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> phase_reg == PH_ACTIVE)
        else $error("result pushed outside an active gesture");

    a_leave_active: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> phase_reg != PH_ACTIVE)
        else $error("tracker stayed active after resolving");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && gesture_stall |-> !push)
        else $error("stalled result overwritten");

    a_tap_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.kind == ttsc_pkg::KIND_SWIPE
            |-> out_reg.norm_x == '0 && out_reg.norm_y == '0)
        else $error("swipe result carries tap coordinates");

endmodule
